FILE: design/nnl_pkg.sv
`default_nettype none
package nnl_pkg;

  // Field widths fixed by the item formats
  localparam int FREQ_W    = 24;
  localparam int SLOT_W    = 7;
  localparam int NOTE_W    = 7;
  localparam int CLASS_W   = 4;
  localparam int OCT_W     = 4;
  localparam int POS_W     = 12;
  localparam int TLEN_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH    = 1'b1;

  localparam logic [TLEN_W-1:0] TABLE_LENGTH_RST = 8'd108;
  localparam logic [POS_W-1:0]  SCR_WIDTH_RST    = 12'd128;

  // Request kinds carried on the input tuser bit
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Position arithmetic widths
  localparam int NUM_W  = FREQ_W + 2;          // 2q - c - l, signed
  localparam int DEN_W  = FREQ_W + 1;          // h - l, signed
  localparam int PROD_W = NUM_W + POS_W + 1;   // num * width, signed
  localparam int DVD_W  = PROD_W;              // 2|p| + |den|
  localparam int DVS_W  = FREQ_W + 1;          // 2|den|
  localparam int QUO_W  = POS_W + 1;           // enough to exceed any width

  // Note class / octave split by multiply with reciprocal of twelve
  localparam int NOTES_PER_OCTAVE = 12;
  localparam int RECIP_12         = 2731;
  localparam int RECIP_W          = 12;
  localparam int RECIP_SHIFT      = 15;
  localparam int OCTAVE_BASE      = 1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             overflow;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: design/nearest_note_locator_core.sv
// Operation: a load writes the table RAM; a query runs a binary search over the
// n searched entries with the S_PROBE/S_CMP loop on the table RAM read port,
// then the bit-serial divider (13 quotient bits).
// Throughput: one request at a time; a finished result waits in the output register.
// Reset: synchronous, active low; the length register returns to 108, the width register
// to 128, the table RAM keeps its contents and is undefined until written.
`default_nettype none
module nearest_note_locator_core #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [6:0] entry_index, [30:7] frequency, [31] zero
  input  wire logic [31:0]                       in_tdata,
  // [0] action
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [6:0] closest_idx, [10:7] note_in_octave, [14:11] octave_number,
  // [26:15] x_position, [27] saturated, [31:28] zero
  output logic [31:0]                            out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [nnl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nnl_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int SW  = IW + 2;
  localparam int CW  = (IW + 1 > nnl_pkg::TLEN_W) ? IW + 1 : nnl_pkg::TLEN_W;
  localparam int SLW = (IW + 1 > nnl_pkg::SLOT_W) ? IW + 1 : nnl_pkg::SLOT_W;
  localparam int MW  = IW + nnl_pkg::RECIP_W;
  localparam int RW  = IW + 4;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_INIT  = 11'b000_0000_0010,
    S_PROBE = 11'b000_0000_0100,
    S_CMP   = 11'b000_0000_1000,
    S_RDL   = 11'b000_0001_0000,
    S_RDH   = 11'b000_0010_0000,
    S_GETH  = 11'b000_0100_0000,
    S_MUL   = 11'b000_1000_0000,
    S_PREP  = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [nnl_pkg::TLEN_W-1:0]   tlen_r;
  logic [nnl_pkg::POS_W-1:0]    swidth_r;

  logic [nnl_pkg::FREQ_W-1:0]   q_r, q_nxt;
  logic [IW-1:0]                last_r, last_nxt;
  logic signed [SW-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IW-1:0]                mid_r, mid_nxt;
  logic [IW-1:0]                best_r, best_nxt;
  logic [nnl_pkg::FREQ_W-1:0]   best_v_r, best_v_nxt;
  logic [nnl_pkg::FREQ_W-1:0]   best_d_r, best_d_nxt;
  logic [nnl_pkg::FREQ_W-1:0]   l_r, l_nxt;
  logic signed [nnl_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic signed [nnl_pkg::DEN_W-1:0]  den_r, den_nxt;
  logic signed [nnl_pkg::PROD_W-1:0] p_r, p_nxt;
  logic                         neg_r, neg_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [31:0]                  out_data_r, out_data_nxt;

  // input unpacking
  logic [nnl_pkg::SLOT_W-1:0]   in_slot;
  logic [nnl_pkg::FREQ_W-1:0]   in_freq;
  logic                         in_acc;

  // table RAM
  logic                         ram_we;
  logic [IW-1:0]                ram_raddr;
  logic [nnl_pkg::FREQ_W-1:0]   ram_rdata;

  // search datapath
  logic [CW-1:0]                tlen_w;
  logic [IW-1:0]                last_cfg;
  logic signed [SW-1:0]         mid_s;
  logic [nnl_pkg::FREQ_W-1:0]   freq_gap;
  logic                         better;
  logic [IW-1:0]                lo_idx, hi_idx;

  // position datapath
  logic [nnl_pkg::DVD_W-1:0]    mag_n;
  logic [nnl_pkg::DEN_W-1:0]    mag_d;
  nnl_pkg::div_req_t            div_req;
  nnl_pkg::div_rsp_t            div_rsp;
  logic [nnl_pkg::POS_W-1:0]    pos_val;
  logic                         sat_val;
  logic [MW-1:0]                recip_prod;
  logic [IW-1:0]                oct_q;
  logic [RW-1:0]                class_w;
  logic [IW:0]                  oct_w;

  assign in_slot   = in_tdata[nnl_pkg::SLOT_W-1:0];
  assign in_freq   = in_tdata[nnl_pkg::SLOT_W +: nnl_pkg::FREQ_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // drop loads whose slot lies past the table
  assign ram_we = in_acc && (in_tuser == nnl_pkg::ACT_LOAD)
                  && (SLW'(in_slot) < SLW'(TABLE_DEPTH));

  nnl_ram #(
    .WIDTH (nnl_pkg::FREQ_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(in_slot)),
    .wdata (in_freq),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r   <= nnl_pkg::TABLE_LENGTH_RST;
      swidth_r <= nnl_pkg::SCR_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnl_pkg::CFG_TABLE_LENGTH: tlen_r   <= cfg_wdata[nnl_pkg::TLEN_W-1:0];
        nnl_pkg::CFG_SCR_WIDTH:    swidth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // last searched index: length clamped to 1..TABLE_DEPTH, minus one
  assign tlen_w = CW'(tlen_r);
  always_comb begin
    priority if (tlen_w == '0) begin
      last_cfg = '0;
    end else if (tlen_w > CW'(TABLE_DEPTH)) begin
      last_cfg = IW'(TABLE_DEPTH - 1);
    end else begin
      last_cfg = IW'(tlen_w - CW'(1));
    end
  end

  assign mid_s    = lo_r + ((hi_r - lo_r) >>> 1);
  assign freq_gap = (ram_rdata > q_r) ? ram_rdata - q_r : q_r - ram_rdata;
  assign better   = (freq_gap < best_d_r)
                    || ((freq_gap == best_d_r) && (ram_rdata > best_v_r));
  assign lo_idx   = (best_r == '0) ? '0 : best_r - IW'(1);
  assign hi_idx   = (best_r < last_r) ? best_r + IW'(1) : last_r;

  always_comb begin
    unique case (state_r)
      S_PROBE: ram_raddr = IW'(mid_s);
      S_RDL:   ram_raddr = lo_idx;
      S_RDH:   ram_raddr = hi_idx;
      default: ram_raddr = '0;
    endcase
  end

  // magnitudes for the rounded quotient
  assign mag_n = p_r[nnl_pkg::PROD_W-1] ? nnl_pkg::DVD_W'(-p_r) : nnl_pkg::DVD_W'(p_r);
  assign mag_d = den_r[nnl_pkg::DEN_W-1] ? nnl_pkg::DEN_W'(-den_r) : nnl_pkg::DEN_W'(den_r);

  always_comb begin
    div_req.start    = (state_r == S_PREP) && (den_r != '0);
    div_req.dividend = (mag_n << 1) + nnl_pkg::DVD_W'(mag_d);
    div_req.divisor  = nnl_pkg::DVS_W'(mag_d) << 1;
  end

  nnl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // round, then clamp to 0..swidth_r
  always_comb begin
    pos_val = '0;
    sat_val = 1'b0;
    if (den_r != '0) begin
      if (neg_r) begin
        sat_val = div_rsp.overflow || (div_rsp.quotient != '0);
      end else if (div_rsp.overflow
                   || (div_rsp.quotient > nnl_pkg::QUO_W'(swidth_r))) begin
        pos_val = swidth_r;
        sat_val = 1'b1;
      end else begin
        pos_val = nnl_pkg::POS_W'(div_rsp.quotient);
      end
    end
  end

  // index / 12 by reciprocal, remainder by back-multiply
  assign recip_prod = MW'(best_r) * MW'(nnl_pkg::RECIP_12);
  assign oct_q      = IW'(recip_prod >> nnl_pkg::RECIP_SHIFT);
  assign class_w    = RW'(best_r) - RW'(oct_q) * RW'(nnl_pkg::NOTES_PER_OCTAVE);
  assign oct_w      = (IW + 1)'(oct_q) + (IW + 1)'(nnl_pkg::OCTAVE_BASE);

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    best_nxt      = best_r;
    best_v_nxt    = best_v_r;
    best_d_nxt    = best_d_r;
    l_nxt         = l_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    p_nxt         = p_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == nnl_pkg::ACT_QUERY)) begin
          q_nxt     = in_freq;
          last_nxt  = last_cfg;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        // entry 0 is the starting best
        best_nxt   = '0;
        best_v_nxt = ram_rdata;
        best_d_nxt = freq_gap;
        lo_nxt     = '0;
        hi_nxt     = SW'(last_r);
        state_nxt  = S_PROBE;
      end
      S_PROBE: begin
        if (lo_r <= hi_r) begin
          mid_nxt   = IW'(mid_s);
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_RDL;
        end
      end
      S_CMP: begin
        if (better || (ram_rdata == q_r)) begin
          best_nxt   = mid_r;
          best_v_nxt = ram_rdata;
          best_d_nxt = freq_gap;
        end
        priority if (ram_rdata == q_r) begin
          state_nxt = S_RDL;
        end else if (ram_rdata < q_r) begin
          lo_nxt    = SW'(mid_r) + SW'(1);
          state_nxt = S_PROBE;
        end else begin
          hi_nxt    = SW'(mid_r) - SW'(1);
          state_nxt = S_PROBE;
        end
      end
      S_RDL: begin
        state_nxt = S_RDH;
      end
      S_RDH: begin
        l_nxt     = ram_rdata;
        state_nxt = S_GETH;
      end
      S_GETH: begin
        num_nxt   = $signed(nnl_pkg::NUM_W'({q_r, 1'b0}))
                    - $signed(nnl_pkg::NUM_W'(best_v_r))
                    - $signed(nnl_pkg::NUM_W'(l_r));
        den_nxt   = $signed(nnl_pkg::DEN_W'(ram_rdata)) - $signed(nnl_pkg::DEN_W'(l_r));
        state_nxt = S_MUL;
      end
      S_MUL: begin
        p_nxt     = nnl_pkg::PROD_W'(num_r) * $signed({1'b0, swidth_r});
        state_nxt = S_PREP;
      end
      S_PREP: begin
        neg_nxt   = p_r[nnl_pkg::PROD_W-1] != den_r[nnl_pkg::DEN_W-1];
        state_nxt = (den_r != '0) ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, sat_val, pos_val,
                           nnl_pkg::OCT_W'(oct_w),
                           nnl_pkg::CLASS_W'(class_w),
                           nnl_pkg::NOTE_W'(best_r)};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_r        <= q_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    best_r     <= best_nxt;
    best_v_r   <= best_v_nxt;
    best_d_r   <= best_d_nxt;
    l_r        <= l_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    p_r        <= p_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: design/nnl_ram.sv
`default_nettype none
module nnl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/nnl_div.sv
`default_nettype none
module nnl_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nnl_pkg::div_req_t req,
  output nnl_pkg::div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(nnl_pkg::QUO_W + 1);

  logic [nnl_pkg::DVD_W-1:0] rem_r, rem_nxt;
  logic [nnl_pkg::DVD_W-1:0] ds_r, ds_nxt;
  logic [nnl_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [nnl_pkg::DVD_W-1:0] dvs_top;
  logic                      ge;

  // Divisor aligned to the top quotient bit and to one past it
  assign dvs_top = nnl_pkg::DVD_W'(req.divisor) << nnl_pkg::QUO_W;
  assign ge      = rem_r >= ds_r;

  always_comb begin
    rem_nxt  = rem_r;
    ds_nxt   = ds_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    if (req.start) begin
      rem_nxt  = req.dividend;
      ds_nxt   = nnl_pkg::DVD_W'(req.divisor) << (nnl_pkg::QUO_W - 1);
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(nnl_pkg::QUO_W);
      busy_nxt = 1'b1;
      ovf_nxt  = req.dividend >= dvs_top;
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      if (ge) begin
        rem_nxt = rem_r - ds_r;
      end
      quo_nxt = {quo_r[nnl_pkg::QUO_W-2:0], ge};
      ds_nxt  = ds_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    ds_r  <= ds_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.overflow = ovf_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire
